FILE: hw/rtl/jfs_pkg.sv
// jfs_pkg: shared types, sizes and helpers for the five-point stencil sweep unit
// no dependencies; compiled first
`default_nettype none

package jfs_pkg;

	localparam int MAX_BLOCK   = 256;
	localparam int VALUE_BITS  = 24;
	localparam int HEAT_BITS   = 40;
	localparam int SIZE_BITS   = 9;
	localparam int BLOCK_RESET = 128;
	localparam int LINE_DEPTH  = MAX_BLOCK + 2;
	localparam int SUM_BITS    = VALUE_BITS + 3;
	localparam int FIFO_DEPTH  = 8;
	localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
	localparam int LVL_BITS    = $clog2(FIFO_DEPTH + 1);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [HEAT_BITS-1:0]  heat_t;
	typedef logic [SIZE_BITS-1:0]  size_t;
	typedef logic [PTR_BITS-1:0]   ptr_t;
	typedef logic [LVL_BITS-1:0]   level_t;

	// one stencil result waiting for heat accumulation
	typedef struct packed {
		value_t new_value;
		logic   last_cell;
	} stencil_res_t;

	// front to queue
	typedef struct packed {
		logic         valid;
		stencil_res_t res;
	} fifo_wr_t;

	// queue status toward front and back
	typedef struct packed {
		logic         not_empty;
		level_t       level;
		stencil_res_t head;
	} fifo_stat_t;

	// size register write: zero reads as one, anything above the maximum saturates
	function automatic size_t clamp_size(input size_t v);
		size_t r;
		r = v;
		if (v == '0) begin
			r = size_t'(1);
		end else if (v > size_t'(MAX_BLOCK)) begin
			r = size_t'(MAX_BLOCK);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/jfs_if.sv
// jfs_cell_if and jfs_result_if: valid/ready request channels of the stencil unit
// depends on jfs_pkg
`default_nettype none

interface jfs_cell_if;
	logic            valid;
	logic            ready;
	jfs_pkg::value_t cell_value;

	modport source(output valid, output cell_value, input ready);
	modport sink(input valid, input cell_value, output ready);
endinterface

interface jfs_result_if;
	logic            valid;
	logic            ready;
	jfs_pkg::value_t new_value;
	jfs_pkg::heat_t  heat_total;
	logic            last_cell;

	modport source(output valid, output new_value, output heat_total, output last_cell,
		input ready);
	modport sink(input valid, input new_value, input heat_total, input last_cell,
		output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/jfs_front.sv
// jfs_front: position tracking, line memory and five-point stencil arithmetic
// depends on jfs_pkg and jfs_cell_if
`default_nettype none

module jfs_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  jfs_pkg::size_t      cfg_wdata,
	jfs_cell_if.sink            cells,
	input  jfs_pkg::fifo_stat_t fifo_stat,
	output jfs_pkg::fifo_wr_t   fifo_wr
);

	localparam int VB = jfs_pkg::VALUE_BITS;
	localparam int SB = jfs_pkg::SUM_BITS;

	jfs_pkg::size_t  size_q, col_q, row_q, size_p1, east_addr;
	logic            accept, col_end, row_end;

	logic            vld_s1;
	jfs_pkg::value_t cell_s1;
	jfs_pkg::size_t  col_s1, row_s1;
	logic            res_s1, last_s1;

	// each word holds {row two back, row one back} of one column
	logic [2*VB-1:0] line_mem [jfs_pkg::LINE_DEPTH];
	logic [2*VB-1:0] rd_word_q;
	jfs_pkg::value_t east_q, west_q;

	jfs_pkg::value_t north, center;
	logic [SB-1:0]   sum;

	logic                  vld_s2;
	jfs_pkg::stencil_res_t res_s2;
	jfs_pkg::level_t       pending;

	assign size_p1 = size_q + jfs_pkg::size_t'(1);
	assign col_end = (col_q == size_p1);
	assign row_end = (row_q == size_p1);

	// right halo column has no stencil, so its east read stays in range
	assign east_addr = col_end ? col_q : col_q + jfs_pkg::size_t'(1);

	// room for every result already in flight
	assign pending = fifo_stat.level + jfs_pkg::level_t'(res_s1) + jfs_pkg::level_t'(vld_s2);
	assign cells.ready = (pending < jfs_pkg::level_t'(jfs_pkg::FIFO_DEPTH));
	assign accept = cells.valid & cells.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= jfs_pkg::size_t'(jfs_pkg::BLOCK_RESET);
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_we) begin
			size_q <= jfs_pkg::clamp_size(cfg_wdata);
			col_q  <= '0;
			row_q  <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + jfs_pkg::size_t'(1);
			end else begin
				col_q <= col_q + jfs_pkg::size_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= cells.cell_value;
			col_s1  <= col_q;
			row_s1  <= row_q;
		end
	end

	// read own and right column on accept, write own column back shifted from stage 1
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_word_q <= line_mem[col_q];
			east_q    <= line_mem[east_addr][VB-1:0];
		end
		if (vld_s1) begin
			line_mem[col_s1] <= {rd_word_q[VB-1:0], cell_s1};
		end
	end

	// row-one value of the previous column, the west neighbor of the next one
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			west_q <= rd_word_q[VB-1:0];
		end
	end

	// stencil for the interior cell above the one in stage 1
	assign north   = rd_word_q[2*VB-1:VB];
	assign center  = rd_word_q[VB-1:0];
	assign res_s1  = vld_s1 && (row_s1 >= jfs_pkg::size_t'(2))
		&& (col_s1 >= jfs_pkg::size_t'(1)) && (col_s1 <= size_q);
	assign last_s1 = (row_s1 == size_p1) && (col_s1 == size_q);
	assign sum = SB'({center, 2'b00})
		+ SB'(north) + SB'(cell_s1)
		+ SB'(west_q) + SB'(east_q);

	always_ff @(posedge clk) begin
		if (res_s1) begin
			res_s2.new_value <= sum[SB-1:3];
			res_s2.last_cell <= last_s1;
		end
	end

	assign fifo_wr.valid = vld_s2;
	assign fifo_wr.res   = res_s2;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (fifo_stat.level < jfs_pkg::level_t'(jfs_pkg::FIFO_DEPTH)))
		else $error("result pushed into a full queue");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= size_p1)
		else $error("column position beyond halo");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= size_p1)
		else $error("row position beyond halo");
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (col_q == '0) && (row_q == '0))
		else $error("size write did not restart the sweep");

endmodule

`default_nettype wire

FILE: hw/rtl/jfs_fifo.sv
// jfs_fifo: short result queue between the stencil front and the heat back end
// depends on jfs_pkg
`default_nettype none

module jfs_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  jfs_pkg::fifo_wr_t   fifo_wr,
	input  wire                 pop,
	output jfs_pkg::fifo_stat_t fifo_stat
);

	jfs_pkg::stencil_res_t entry_q [jfs_pkg::FIFO_DEPTH];
	jfs_pkg::ptr_t         wr_ptr_q, rd_ptr_q;
	jfs_pkg::level_t       level_q;

	always_ff @(posedge clk) begin
		if (fifo_wr.valid) begin
			entry_q[wr_ptr_q] <= fifo_wr.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (fifo_wr.valid) begin
				wr_ptr_q <= wr_ptr_q + jfs_pkg::ptr_t'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + jfs_pkg::ptr_t'(1);
			end
			case ({fifo_wr.valid, pop})
				2'b10:   level_q <= level_q + jfs_pkg::level_t'(1);
				2'b01:   level_q <= level_q - jfs_pkg::level_t'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	assign fifo_stat.not_empty = (level_q != '0);
	assign fifo_stat.level     = level_q;
	assign fifo_stat.head      = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: hw/rtl/jfs_back.sv
// jfs_back: running heat sum and registered result output
// depends on jfs_pkg and jfs_result_if
`default_nettype none

module jfs_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  jfs_pkg::fifo_stat_t fifo_stat,
	output logic                pop,
	jfs_result_if.source        results
);

	jfs_pkg::heat_t  heat_q, heat_next;
	logic            out_vld_q;
	jfs_pkg::value_t out_value_q;
	jfs_pkg::heat_t  out_heat_q;
	logic            out_last_q;

	assign pop       = fifo_stat.not_empty && (!out_vld_q || results.ready);
	assign heat_next = heat_q + jfs_pkg::heat_t'(fifo_stat.head.new_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				heat_q <= '0;
			end else if (pop) begin
				heat_q <= fifo_stat.head.last_cell ? '0 : heat_next;
			end
			if (pop) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_value_q <= fifo_stat.head.new_value;
			out_heat_q  <= heat_next;
			out_last_q  <= fifo_stat.head.last_cell;
		end
	end

	assign results.valid      = out_vld_q;
	assign results.new_value  = out_value_q;
	assign results.heat_total = out_heat_q;
	assign results.last_cell  = out_last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/jacobi_five_point_stencil_sweep_unit.sv
// jacobi_five_point_stencil_sweep_unit: top level of the five-point stencil sweep
// depends on jfs_pkg, jfs_if, jfs_front, jfs_fifo and jfs_back
`default_nettype none

// streams one jacobi sweep over a square block of interior cells, as many per row and
// column as the size register holds, with a one-cell halo, taking (size+2)^2 cells in
// row-major order, one request per cycle at full rate. the rate is set by a single
// 258 x 48 line memory holding the two previous rows per column: each cell costs two
// reads of it (its own column and the one to its right) and one write. for each
// interior cell the unit returns (4*center + n + s + e + w) >> 3 and the running heat
// sum of the sweep; the result passes the stage-1 and stage-2 registers, the queue and
// the output register. an eight-entry queue lets the input run on while the output
// stalls; the input stalls once the queue and the results in flight fill it.
// a write of the size register restarts the sweep and should happen only while no
// result is pending.
module jacobi_five_point_stencil_sweep_unit (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cfg_we,
	input  jfs_pkg::size_t cfg_wdata,
	jfs_cell_if.sink       cells,
	jfs_result_if.source   results
);

	jfs_pkg::fifo_wr_t   fifo_wr;
	jfs_pkg::fifo_stat_t fifo_stat;
	logic                pop;

	// front: positions, line memory, stencil adder; stalls only on queue room
	jfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cells     (cells),
		.fifo_stat (fifo_stat),
		.fifo_wr   (fifo_wr)
	);

	// queue decouples the stencil pipe from output backpressure
	jfs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_wr   (fifo_wr),
		.pop       (pop),
		.fifo_stat (fifo_stat)
	);

	// back: heat accumulation and output register
	jfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.results   (results)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for jacobi_five_point_stencil_sweep_unit
// needs jfs_pkg, jfs_if and the unit's rtl; predicts every stencil update in-line

module testbench;

	// cycles allowed after the last expected update before touching the size register
	localparam int SETTLE_CYCLES     = 16;
	// long receiver hold-off so the internal queue fills and cells stall
	localparam int SINK_HOLD_CYCLES  = 250;
	localparam int RANDOM_CELLS      = 150;
	localparam int IDLE_PERCENT      = 31;

	// one expected stencil update as it should leave the unit
	typedef struct {
		jfs_pkg::value_t new_value;
		jfs_pkg::heat_t  heat_total;
		logic            last_cell;
	} stencil_update_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	jfs_pkg::size_t cfg_wdata;

	jfs_cell_if   cell_ch ();
	jfs_result_if result_ch ();

	jacobi_five_point_stencil_sweep_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cells     (cell_ch),
		.results   (result_ch)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// stencil predictor: its own line buffers, sweep position and heat sum
	// ------------------------------------------------------------------
	jfs_pkg::value_t grid_row_above [jfs_pkg::LINE_DEPTH];   // row just before the current one
	jfs_pkg::value_t grid_row_second[jfs_pkg::LINE_DEPTH];   // the row before that
	int unsigned     sweep_col;
	int unsigned     sweep_row;
	jfs_pkg::heat_t  sweep_heat;
	int unsigned     active_size;               // block edge length as the unit applies it

	stencil_update_t pending_updates[$];    // updates still owed by the unit

	int unsigned mismatch_count;
	int unsigned cells_sent;
	int unsigned holds_requested;
	int unsigned holds_served;
	bit          no_idle;                   // both sides run flat out while set

	function automatic void restart_prediction();
		sweep_col  = 0;
		sweep_row  = 0;
		sweep_heat = '0;
	endfunction

	// feed one accepted cell through the predictor; an update is owed when the
	// cell lies below an interior cell (row 2 and later, interior column)
	function automatic void apply_stencil_cell(input jfs_pkg::value_t cell_in);
		logic [jfs_pkg::SUM_BITS-1:0] weighted;
		stencil_update_t              upd;
		int unsigned                  s;
		int unsigned                  c;
		int unsigned                  r;
		s = active_size;
		c = sweep_col;
		r = sweep_row;
		if (r >= 2 && c >= 1 && c <= s) begin
			// the west neighbor already moved down into the second buffer this row
			weighted = jfs_pkg::SUM_BITS'({grid_row_above[c], 2'b00})
				+ jfs_pkg::SUM_BITS'(grid_row_second[c])
				+ jfs_pkg::SUM_BITS'(grid_row_second[c-1])
				+ jfs_pkg::SUM_BITS'(grid_row_above[c+1])
				+ jfs_pkg::SUM_BITS'(cell_in);
			upd.new_value  = weighted[jfs_pkg::SUM_BITS-1:3];
			sweep_heat     = sweep_heat + jfs_pkg::heat_t'(upd.new_value);
			upd.heat_total = sweep_heat;
			upd.last_cell  = (r == s + 1 && c == s);
			pending_updates.push_back(upd);
		end
		grid_row_second[c] = grid_row_above[c];
		grid_row_above[c]  = cell_in;
		if (c == s + 1) begin
			sweep_col = 0;
			if (r == s + 1) begin
				// last halo cell closes the sweep
				restart_prediction();
			end else begin
				sweep_row = r + 1;
			end
		end else begin
			sweep_col = c + 1;
		end
	endfunction

	// mostly random cells, with the extremes and single bits mixed in
	function automatic jfs_pkg::value_t pick_cell_value();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 12) begin
			return '0;
		end else if (roll < 24) begin
			return '1;
		end else if (roll < 32) begin
			return jfs_pkg::value_t'(1) << $urandom_range(jfs_pkg::VALUE_BITS - 1);
		end
		return jfs_pkg::value_t'($urandom());
	endfunction

	// ------------------------------------------------------------------
	// cell side
	// ------------------------------------------------------------------

	// offer one cell request, with a random gap first unless running flat out
	task automatic send_cell(input jfs_pkg::value_t v);
		while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			cell_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cell_ch.valid      <= 1'b1;
		cell_ch.cell_value <= v;
		@(posedge clk);
		while (!cell_ch.ready) begin
			@(posedge clk);
		end
		apply_stencil_cell(v);
		cells_sent++;
	endtask

	// a run of random cells in stream order
	task automatic send_cells(input int unsigned count);
		repeat (count) begin
			send_cell(pick_cell_value());
		end
	endtask

	// whole rows of the current size
	task automatic send_rows(input int unsigned nrows);
		send_cells(nrows * (active_size + 2));
	endtask

	// stop offering and wait until the unit has returned every owed update;
	// with settle set, also let the pipeline run dry before a size write
	task automatic await_updates(input bit settle);
		cell_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_updates.size() != 0) begin
			@(posedge clk);
		end
		if (settle) begin
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	// size register write; only called while the unit is idle
	task automatic write_block_size(input jfs_pkg::size_t v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (v == '0) begin
			active_size = 1;
		end else if (v > jfs_pkg::MAX_BLOCK) begin
			active_size = jfs_pkg::MAX_BLOCK;
		end else begin
			active_size = v;
		end
		restart_prediction();
	endtask

	// ------------------------------------------------------------------
	// result side: ready pattern with a counted long hold, and the checker
	// ------------------------------------------------------------------
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_requested) begin
				holds_served = holds_requested;
				hold_left    = SINK_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (no_idle) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// every accepted result is matched against the oldest owed update
	always @(posedge clk) begin
		stencil_update_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_updates.size() == 0) begin
				$error("unexpected result: new_value %h heat_total %h last_cell %b",
					result_ch.new_value, result_ch.heat_total, result_ch.last_cell);
				mismatch_count++;
			end else begin
				want = pending_updates.pop_front();
				if (result_ch.new_value !== want.new_value) begin
					$error("new_value mismatch: expected %h, actual %h",
						want.new_value, result_ch.new_value);
					mismatch_count++;
				end
				if (result_ch.heat_total !== want.heat_total) begin
					$error("heat_total mismatch: expected %h, actual %h",
						want.heat_total, result_ch.heat_total);
					mismatch_count++;
				end
				if (result_ch.last_cell !== want.last_cell) begin
					$error("last_cell mismatch: expected %b, actual %b",
						want.last_cell, result_ch.last_cell);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// no write yet: the first rows must follow the reset size of 128;
	// two full rows and the start of the third give the first few updates
	task automatic test_reset_size();
		send_cells(2 * (active_size + 2) + 4);
		await_updates(1'b1);
	endtask

	// single-cell blocks: size 0 reads as 1; all-ones, lone center, odd lsbs.
	// the three sweeps run back to back so the end-of-sweep wrap is exercised
	task automatic test_directed_extremes();
		jfs_pkg::value_t lone_center[9];
		jfs_pkg::value_t tiny_sum[9];
		for (int i = 0; i < 9; i++) begin
			lone_center[i] = '0;
			tiny_sum[i]    = jfs_pkg::value_t'(1);
		end
		lone_center[4] = '1;      // 4*max >> 3 truncates to half scale
		write_block_size('0);
		repeat (9) send_cell('1);
		for (int i = 0; i < 9; i++) begin
			send_cell(lone_center[i]);
		end
		for (int i = 0; i < 9; i++) begin
			send_cell(tiny_sum[i]);
		end
		await_updates(1'b1);
	endtask

	// largest block via an oversized write, only up to the first updates
	task automatic test_size_limits();
		write_block_size(jfs_pkg::size_t'(9'h1FF));
		send_cells(2 * (active_size + 2) + 4);
		await_updates(1'b1);
	endtask

	// a size write in the middle of a sweep restarts positions and heat
	task automatic test_mid_sweep_restart();
		write_block_size(jfs_pkg::size_t'(5));
		send_rows(3);
		await_updates(1'b1);
		write_block_size(jfs_pkg::size_t'(5));
		send_rows(7);
		await_updates(1'b1);
		write_block_size(jfs_pkg::size_t'(4));
		send_rows(1);                // top halo only, nothing owed
		await_updates(1'b1);
		write_block_size(jfs_pkg::size_t'(2));
		send_rows(4);
		await_updates(1'b1);
	endtask

	// receiver holds off while cells keep coming, filling the unit up
	task automatic test_back_pressure();
		write_block_size(jfs_pkg::size_t'(4));
		no_idle = 1'b1;
		holds_requested++;
		send_rows(12);
		await_updates(1'b1);
		no_idle = 1'b0;
	endtask

	// sender stops after each row until everything owed has come back
	task automatic test_sender_pause();
		write_block_size(jfs_pkg::size_t'(3));
		for (int r = 0; r < 6; r++) begin
			send_rows(1);
			await_updates(1'b0);
		end
		await_updates(1'b1);
	endtask

	// random sizes and contents; mostly complete sweeps, some cut short
	task automatic test_random_sweeps();
		int unsigned start_count;
		int unsigned roll;
		int unsigned size_pick;
		int unsigned rows_pick;
		start_count = cells_sent;
		while (cells_sent - start_count < RANDOM_CELLS) begin
			// one stretch with no gaps on either side
			no_idle = (cells_sent - start_count < 60);
			roll = $urandom_range(99);
			if (roll < 5) begin
				size_pick = 0;
			end else if (roll < 85) begin
				size_pick = $urandom_range(6, 1);
			end else begin
				size_pick = $urandom_range(10, 7);
			end
			write_block_size(jfs_pkg::size_t'(size_pick));
			if ($urandom_range(99) < 85) begin
				// one or two sweeps back to back
				send_rows($urandom_range(2, 1) * (active_size + 2));
			end else begin
				rows_pick = $urandom_range(active_size + 1);
				send_rows(rows_pick);
			end
			await_updates(1'b1);
		end
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// main flow
	// ------------------------------------------------------------------
	initial begin
		mismatch_count  = 0;
		cells_sent      = 0;
		holds_requested = 0;
		holds_served    = 0;
		no_idle         = 1'b0;
		active_size     = jfs_pkg::BLOCK_RESET;
		for (int i = 0; i < jfs_pkg::LINE_DEPTH; i++) begin
			grid_row_above[i]  = '0;
			grid_row_second[i] = '0;
		end
		restart_prediction();

		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		cell_ch.valid      <= 1'b0;
		cell_ch.cell_value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size();
		test_directed_extremes();
		test_size_limits();
		test_mid_sweep_restart();
		test_back_pressure();
		test_sender_pause();
		test_random_sweeps();

		await_updates(1'b1);
		if (mismatch_count == 0 && pending_updates.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

endmodule
